// ----- rtl/core/scrd_pkg.sv -----
// Shared types and constants of the scanline color run detector.
package scrd_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned MAX_COINS = 8;

  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W     = $clog2(MAX_COINS + 1);
  localparam int unsigned WIDE_W    = (COL_W + 2 > 12) ? COL_W + 2 : 12;
  localparam int unsigned OUT_COL_W = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_GAP = 2'd3;

  localparam logic [7:0]       SAT_MIN_RST   = 8'd90;
  localparam logic [7:0]       VAL_MIN_RST   = 8'd40;
  localparam logic [CFG_W-1:0] MIN_RUN_RST   = 11'd6;
  localparam logic [7:0]       BOUND_GAP_RST = 8'd3;

  // Red wraps around the hue circle: at or below RED_HUE_MAX, or at or above RED_HUE_MIN.
  localparam logic [7:0] RED_HUE_MAX = 8'd18;
  localparam logic [7:0] RED_HUE_MIN = 8'd238;
  localparam logic [7:0] YEL_HUE_MIN = 8'd30;
  localparam logic [7:0] YEL_HUE_MAX = 8'd60;
  localparam logic [7:0] BLU_HUE_MIN = 8'd140;
  localparam logic [7:0] BLU_HUE_MAX = 8'd180;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CLR_RED    = 2'd0,
    CLR_YELLOW = 2'd1,
    CLR_BLUE   = 2'd2,
    CLR_NONE   = 2'd3
  } color_e;

  typedef struct packed {
    logic [7:0]       sat_min;
    logic [7:0]       val_min;
    logic [CFG_W-1:0] min_run_width;
    logic [7:0]       bound_gap;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic [9:0]  track_lo;
    logic [9:0]  track_hi;
    logic        row_last;
  } pix_t;

  typedef struct packed {
    logic                 coin_valid;
    logic [1:0]           coin_color;
    logic [OUT_COL_W-1:0] left_col;
    logic [OUT_COL_W-1:0] right_col;
    logic [OUT_COL_W-1:0] center_col;
    logic                 row_end;
  } coin_t;

  // Up to two result items produced by one pixel, in output order.
  typedef struct packed {
    logic [1:0] num;
    coin_t      first;
    coin_t      second;
  } res_t;

endpackage

// ----- rtl/core/scrd_run_tracker.sv -----
// Per-row run state: pixel classification, run closing and coin tests.
module scrd_run_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  scrd_pkg::pix_t pix_i,
  input  scrd_pkg::cfg_t cfg_i,
  output scrd_pkg::res_t res_o
);
  import scrd_pkg::*;

  typedef struct packed {
    logic              keep;
    logic [WIDE_W-1:0] left;
    logic [WIDE_W-1:0] right;
    logic [WIDE_W-1:0] center;
  } judge_t;

  logic [COL_W-1:0] column_q, column_d;
  color_e           run_col_q, run_col_d;
  logic [COL_W-1:0] run_begin_q, run_begin_d;
  logic [CNT_W-1:0] coins_q, coins_d;

  color_e           color;
  color_e           open_col;
  logic [COL_W-1:0] open_begin;
  logic             change, close1, close2;
  logic             full1, full2;
  logic [CNT_W-1:0] coins_mid;
  judge_t           j1, j2;
  logic             k1, k2;
  logic [WIDE_W-1:0] x_w;
  coin_t            coin1, coin2, empty_coin;

  function automatic judge_t judge(logic [WIDE_W-1:0] first, logic [WIDE_W-1:0] last,
                                   logic [9:0] lo, logic [9:0] hi, cfg_t cfg,
                                   logic full);
    judge_t            r;
    logic [WIDE_W-1:0] len;
    logic [WIDE_W-1:0] sum;
    logic [WIDE_W-1:0] ctr;
    logic [WIDE_W-1:0] lo_b;
    logic [WIDE_W-1:0] ctr_m;
    len   = last - first + WIDE_W'(1);
    sum   = first + last;
    ctr   = sum >> 1;
    lo_b  = WIDE_W'(lo) + WIDE_W'(cfg.bound_gap);
    ctr_m = ctr + WIDE_W'(cfg.bound_gap);
    r.keep   = (len >= WIDE_W'(cfg.min_run_width)) && !full &&
               (ctr >= lo_b) && (ctr_m <= WIDE_W'(hi));
    r.left   = first;
    r.right  = last;
    r.center = ctr;
    return r;
  endfunction

  function automatic coin_t make_coin(color_e col, judge_t j);
    coin_t c;
    c.coin_valid = 1'b1;
    c.coin_color = col;
    c.left_col   = j.left[OUT_COL_W-1:0];
    c.right_col  = j.right[OUT_COL_W-1:0];
    c.center_col = j.center[OUT_COL_W-1:0];
    c.row_end    = 1'b0;
    return c;
  endfunction

  // Hue bands apply only to saturated, bright pixels.
  always_comb begin
    color = CLR_NONE;
    if (pix_i.saturation >= cfg_i.sat_min && pix_i.brightness >= cfg_i.val_min) begin
      if (pix_i.hue <= RED_HUE_MAX || pix_i.hue >= RED_HUE_MIN) begin
        color = CLR_RED;
      end else if (pix_i.hue >= YEL_HUE_MIN && pix_i.hue <= YEL_HUE_MAX) begin
        color = CLR_YELLOW;
      end else if (pix_i.hue >= BLU_HUE_MIN && pix_i.hue <= BLU_HUE_MAX) begin
        color = CLR_BLUE;
      end
    end
  end

  always_comb begin
    x_w        = WIDE_W'(column_q);
    change     = (color != run_col_q);
    close1     = change && (run_col_q != CLR_NONE);
    full1      = (coins_q >= CNT_W'(MAX_COINS));
    j1         = judge(WIDE_W'(run_begin_q), x_w - WIDE_W'(1), pix_i.track_lo,
                       pix_i.track_hi, cfg_i, full1);
    k1         = close1 && j1.keep;

    open_col   = change ? color : run_col_q;
    open_begin = change ? ((color != CLR_NONE) ? column_q : '0) : run_begin_q;

    coins_mid  = coins_q + CNT_W'(k1);
    full2      = (coins_mid >= CNT_W'(MAX_COINS));
    close2     = pix_i.row_last && (open_col != CLR_NONE);
    j2         = judge(WIDE_W'(open_begin), x_w, pix_i.track_lo, pix_i.track_hi,
                       cfg_i, full2);
    k2         = close2 && j2.keep;

    coin1      = make_coin(run_col_q, j1);
    coin2      = make_coin(open_col, j2);
    empty_coin = '0;

    res_o = '0;
    if (step_i) begin
      if (!pix_i.row_last) begin
        res_o.num   = {1'b0, k1};
        res_o.first = coin1;
      end else if (k1 && k2) begin
        res_o.num            = 2'd2;
        res_o.first          = coin1;
        res_o.second         = coin2;
        res_o.second.row_end = 1'b1;
      end else begin
        res_o.num           = 2'd1;
        res_o.first         = k1 ? coin1 : (k2 ? coin2 : empty_coin);
        res_o.first.row_end = 1'b1;
      end
    end
  end

  always_comb begin
    column_d    = column_q;
    run_col_d   = run_col_q;
    run_begin_d = run_begin_q;
    coins_d     = coins_q;
    if (step_i) begin
      if (pix_i.row_last) begin
        column_d    = '0;
        run_col_d   = CLR_NONE;
        run_begin_d = '0;
        coins_d     = '0;
      end else begin
        // Saturate the column at the last position.
        if (column_q < COL_W'(MAX_WIDTH - 1)) begin
          column_d = column_q + COL_W'(1);
        end
        run_col_d   = open_col;
        run_begin_d = open_begin;
        coins_d     = coins_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      run_col_q   <= CLR_NONE;
      run_begin_q <= '0;
      coins_q     <= '0;
    end else begin
      column_q    <= column_d;
      run_col_q   <= run_col_d;
      run_begin_q <= run_begin_d;
      coins_q     <= coins_d;
    end
  end

  a_row_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pix_i.row_last |-> res_o.num != 2'd0)
    else $error("row end produced no result item");

  a_coin_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coins_q <= CNT_W'(MAX_COINS))
    else $error("coin count above limit");

  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pix_i.row_last |=> column_q == '0 && run_col_q == CLR_NONE && coins_q == '0)
    else $error("row state not cleared after last pixel");

endmodule

// ----- rtl/core/scrd_out_fifo.sv -----
// Result queue: takes up to two items per cycle, hands out one unless stalled.
module scrd_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scrd_pkg::res_t res_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output scrd_pkg::coin_t head_o
);
  import scrd_pkg::*;

  coin_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;
  logic              pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  // Leave space for the two items a row-end pixel may bring.
  assign room_o      = (count_q <= FCNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(res_i.num);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + FCNT_W'(res_i.num) - FCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (res_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= res_i.first;
    end
    if (res_i.num == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= res_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FCNT_W'(res_i.num) + count_q <= FCNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FCNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PTR_W'(wr_ptr_q - rd_ptr_q) == PTR_W'(count_q))
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/scanline_color_run_detector.sv -----
// Top level of the scanline color run detector: config, input stage, run logic, result queue.
//
//   channel | dir | handshake                 | payload
//   in      | in  | in_valid_i / in_stall_o   | hue, saturation, brightness, track bounds, row_last
//   out     | out | out_valid_o / out_stall_i | coin_valid, coin_color, columns, row_end
//   cfg     | in  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One pixel item is taken per cycle unless stalled; it is registered, then its results are queued.
// A row-end pixel can yield two items, which leave the 4-entry queue one per cycle unless stalled.
// The input stalls only while the queue holds more than two items and a pixel waits.
// Reset clears run state and queue and loads config defaults at once; there is no clearing pass.
module scanline_color_run_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scrd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [scrd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    hue_i,
  input  logic [7:0]                    saturation_i,
  input  logic [7:0]                    brightness_i,
  input  logic [9:0]                    track_lo_i,
  input  logic [9:0]                    track_hi_i,
  input  logic                          row_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          coin_valid_o,
  output logic [1:0]                    coin_color_o,
  output logic [9:0]                    left_col_o,
  output logic [9:0]                    right_col_o,
  output logic [9:0]                    center_col_o,
  output logic                          row_end_o
);
  import scrd_pkg::*;

  cfg_t  cfg_q;
  pix_t  pix_q;
  logic  pix_valid_q, pix_valid_d;
  logic  room;
  logic  step;
  logic  in_accept;
  res_t  res;
  coin_t head;

  assign step       = pix_valid_q && room;
  assign in_stall_o = pix_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    pix_valid_d = pix_valid_q;
    if (in_accept) begin
      pix_valid_d = 1'b1;
    end else if (step) begin
      pix_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q.hue        <= hue_i;
      pix_q.saturation <= saturation_i;
      pix_q.brightness <= brightness_i;
      pix_q.track_lo   <= track_lo_i;
      pix_q.track_hi   <= track_hi_i;
      pix_q.row_last   <= row_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sat_min       <= SAT_MIN_RST;
      cfg_q.val_min       <= VAL_MIN_RST;
      cfg_q.min_run_width <= MIN_RUN_RST;
      cfg_q.bound_gap     <= BOUND_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAT_MIN:   cfg_q.sat_min       <= cfg_data_i[7:0];
        REG_VAL_MIN:   cfg_q.val_min       <= cfg_data_i[7:0];
        REG_MIN_RUN:   cfg_q.min_run_width <= cfg_data_i;
        REG_BOUND_GAP: cfg_q.bound_gap     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  scrd_run_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pix_i  (pix_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  scrd_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign coin_valid_o = head.coin_valid;
  assign coin_color_o = head.coin_color;
  assign left_col_o   = head.left_col;
  assign right_col_o  = head.right_col;
  assign center_col_o = head.center_col;
  assign row_end_o    = head.row_end;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pix_valid_q)
    else $error("input stalled with an empty input stage");

  a_step_pushes_or_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |-> res.num == 2'd0)
    else $error("result pushed without a pixel step");

  a_pixel_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> pix_valid_q)
    else $error("stalled pixel dropped");

endmodule

// ----- dv/testbench.sv -----
// Testbench for scanline_color_run_detector: run-tracking predictor, queue of expected coins.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scrd_pkg::*;

  class coin_tracker;
    logic [7:0]       sat_min = SAT_MIN_RST;
    logic [7:0]       val_min = VAL_MIN_RST;
    logic [CFG_W-1:0] min_run = MIN_RUN_RST;
    logic [7:0]       margin  = BOUND_GAP_RST;
    logic [9:0]       column  = '0;
    color_e           open_clr = CLR_NONE;
    logic [9:0]       run_begin = '0;
    int               coins_in_row = 0;
    coin_t            coins_due[$];
    int               errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SAT_MIN:   sat_min = data[7:0];
        REG_VAL_MIN:   val_min = data[7:0];
        REG_MIN_RUN:   min_run = data;
        REG_BOUND_GAP: margin  = data[7:0];
        default: ;
      endcase
    endfunction

    // Close a run and queue a coin if it passes width, count and track tests.
    function bit judge(color_e clr, int head, int tail, pix_t p);
      int    len;
      int    sum;
      int    center;
      coin_t c;
      len = tail - head + 1;
      sum = head + tail;
      if (len < int'(min_run)) return 0;
      if (coins_in_row >= MAX_COINS) return 0;
      center = (sum >= 0) ? sum / 2 : -((1 - sum) / 2);
      if (center < int'(p.track_lo) + int'(margin)) return 0;
      if (center > int'(p.track_hi) - int'(margin)) return 0;
      c.coin_valid = 1'b1;
      c.coin_color = clr;
      c.left_col   = 10'(head);
      c.right_col  = 10'(tail);
      c.center_col = 10'(center);
      c.row_end    = 1'b0;
      coins_due.push_back(c);
      coins_in_row++;
      return 1;
    endfunction

    function void note_pixel(pix_t p);
      color_e clr;
      int     col;
      int     made;
      coin_t  c;
      clr  = CLR_NONE;
      col  = int'(column);
      made = 0;
      if (p.saturation >= sat_min && p.brightness >= val_min) begin
        if (p.hue <= RED_HUE_MAX || p.hue >= RED_HUE_MIN) clr = CLR_RED;
        else if (p.hue >= YEL_HUE_MIN && p.hue <= YEL_HUE_MAX) clr = CLR_YELLOW;
        else if (p.hue >= BLU_HUE_MIN && p.hue <= BLU_HUE_MAX) clr = CLR_BLUE;
      end
      if (clr != open_clr) begin
        if (open_clr != CLR_NONE) made += judge(open_clr, int'(run_begin), col - 1, p);
        open_clr  = clr;
        run_begin = (clr != CLR_NONE) ? column : '0;
      end
      if (!p.row_last) begin
        if (column < MAX_WIDTH - 1) column++;
        return;
      end
      if (open_clr != CLR_NONE) made += judge(open_clr, int'(run_begin), col, p);
      // Flag the row end on the last coin, or on an empty item when none was kept.
      if (made == 0) c = '0;
      else c = coins_due.pop_back();
      c.row_end = 1'b1;
      coins_due.push_back(c);
      column       = '0;
      open_clr     = CLR_NONE;
      run_begin    = '0;
      coins_in_row = 0;
    endfunction

    function void compare(string field, logic [9:0] want, logic [9:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_coin(coin_t got);
      coin_t want;
      if (coins_due.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
        return;
      end
      want = coins_due.pop_front();
      compare("coin_valid", 10'(want.coin_valid), 10'(got.coin_valid));
      compare("coin_color", 10'(want.coin_color), 10'(got.coin_color));
      compare("left_col", want.left_col, got.left_col);
      compare("right_col", want.right_col, got.right_col);
      compare("center_col", want.center_col, got.center_col);
      compare("row_end", 10'(want.row_end), 10'(got.row_end));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           hue_i;
  logic [7:0]           saturation_i;
  logic [7:0]           brightness_i;
  logic [9:0]           track_lo_i;
  logic [9:0]           track_hi_i;
  logic                 row_last_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 coin_valid_o;
  logic [1:0]           coin_color_o;
  logic [9:0]           left_col_o;
  logic [9:0]           right_col_o;
  logic [9:0]           center_col_o;
  logic                 row_end_o;

  coin_tracker tracker = new();
  coin_t       seen;
  int          gap_pct = 0;
  int          stall_pct = 0;
  logic [7:0]  band_hues [12] = '{8'd0, 8'd255, 8'd18, 8'd19, 8'd30, 8'd60,
                                  8'd61, 8'd140, 8'd180, 8'd181, 8'd237, 8'd238};

  scanline_color_run_detector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .track_lo_i   (track_lo_i),
    .track_hi_i   (track_hi_i),
    .row_last_i   (row_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .coin_valid_o (coin_valid_o),
    .coin_color_o (coin_color_o),
    .left_col_o   (left_col_o),
    .right_col_o  (right_col_o),
    .center_col_o (center_col_o),
    .row_end_o    (row_end_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: stall in random bursts at the rate of the current phase.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.coin_valid = coin_valid_o;
      seen.coin_color = coin_color_o;
      seen.left_col   = left_col_o;
      seen.right_col  = right_col_o;
      seen.center_col = center_col_o;
      seen.row_end    = row_end_o;
      tracker.check_coin(seen);
    end
  end

  function automatic pix_t px(logic [7:0] h, logic [7:0] s, logic [7:0] v,
                              logic [9:0] lo, logic [9:0] hi, logic tail);
    pix_t p;
    p.hue        = h;
    p.saturation = s;
    p.brightness = v;
    p.track_lo   = lo;
    p.track_hi   = hi;
    p.row_last   = tail;
    return p;
  endfunction

  // Build a pixel of the wanted class under the current thresholds.
  function automatic pix_t make_pixel(color_e want);
    pix_t p;
    p = '0;
    p.saturation = 8'($urandom_range(tracker.sat_min, 255));
    p.brightness = 8'($urandom_range(tracker.val_min, 255));
    case (want)
      CLR_RED: p.hue = 8'($urandom_range(0, 1) ? $urandom_range(0, RED_HUE_MAX)
                                                : $urandom_range(RED_HUE_MIN, 255));
      CLR_YELLOW: p.hue = 8'($urandom_range(YEL_HUE_MIN, YEL_HUE_MAX));
      CLR_BLUE: p.hue = 8'($urandom_range(BLU_HUE_MIN, BLU_HUE_MAX));
      default: begin
        p.hue = 8'($urandom());
        case ($urandom_range(0, 2))
          1: if (tracker.sat_min != 0)
               p.saturation = 8'($urandom_range(0, tracker.sat_min - 1));
             else p.hue = 8'($urandom_range(YEL_HUE_MAX + 1, BLU_HUE_MIN - 1));
          2: if (tracker.val_min != 0)
               p.brightness = 8'($urandom_range(0, tracker.val_min - 1));
             else p.hue = 8'($urandom_range(BLU_HUE_MAX + 1, RED_HUE_MIN - 1));
          default: p.hue = 8'($urandom_range(RED_HUE_MAX + 1, YEL_HUE_MIN - 1));
        endcase
      end
    endcase
    return p;
  endfunction

  task automatic push_pixel(input pix_t p);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hue_i        <= p.hue;
    saturation_i <= p.saturation;
    brightness_i <= p.brightness;
    track_lo_i   <= p.track_lo;
    track_hi_i   <= p.track_hi;
    row_last_i   <= p.row_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_pixel(p);
  endtask

  // Hold the input idle until every expected coin is out, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.coins_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(input int unsigned sat, input int unsigned val,
                           input int unsigned run, input int unsigned mrg);
    put_reg(REG_SAT_MIN, CFG_W'(sat));
    put_reg(REG_VAL_MIN, CFG_W'(val));
    put_reg(REG_MIN_RUN, CFG_W'(run));
    put_reg(REG_BOUND_GAP, CFG_W'(mrg));
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_idle();
    gap_pct   = 10 * $urandom_range(0, 2);
    stall_pct = 6 * $urandom_range(0, 2);
  endtask

  // Send one row of colored runs with random content; noisy rows scramble pixels and bounds.
  task automatic send_row(input int len, input bit noisy);
    pix_t       p;
    color_e     clr;
    int         run_left;
    int         top;
    logic [9:0] lo;
    logic [9:0] hi;
    if ($urandom_range(0, 7) == 0) begin
      lo = 10'($urandom());
      hi = 10'($urandom());
    end else begin
      lo = 10'($urandom_range(0, 12));
      hi = 10'($urandom_range(len / 2, (len + 8 > 1023) ? 1023 : len + 8));
    end
    top      = (int'(tracker.min_run) < 16) ? 2 * int'(tracker.min_run) + 2 : 40;
    run_left = 0;
    clr      = CLR_NONE;
    for (int col = 0; col < len; col++) begin
      if (run_left == 0) begin
        clr      = color_e'($urandom_range(0, 3));
        run_left = $urandom_range(1, top);
      end
      run_left--;
      p = make_pixel(clr);
      if (noisy || $urandom_range(0, 19) == 0) begin
        p.hue        = 8'($urandom());
        p.saturation = 8'($urandom());
        p.brightness = 8'($urandom());
      end
      p.track_lo = lo;
      p.track_hi = hi;
      if (noisy && $urandom_range(0, 1)) begin
        p.track_lo = 10'($urandom());
        p.track_hi = 10'($urandom());
      end
      p.row_last = (col == len - 1);
      push_pixel(p);
    end
  endtask

  task automatic run_phase(input int items, input int noisy_pct);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 48);
      send_row(len, $urandom_range(0, 99) < noisy_pct);
      sent += len;
    end
    drain();
  endtask

  initial begin
    pix_t p;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_SAT_MIN;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    hue_i        <= '0;
    saturation_i <= '0;
    brightness_i <= '0;
    track_lo_i   <= '0;
    track_hi_i   <= '0;
    row_last_i   <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: hue band edges, threshold edges, two coins on one row end,
    // a lone empty row, and a run rejected by inverted track bounds.
    pick_idle();
    configure(SAT_MIN_RST, VAL_MIN_RST, 1, 0);
    for (int i = 0; i < 12; i++)
      push_pixel(px(band_hues[i], 8'd200, 8'd200, 10'd0, 10'h3FF, i == 11));
    push_pixel(px(8'd40, 8'd89, 8'd200, 10'd0, 10'h3FF, 1'b0));
    push_pixel(px(8'd40, 8'd90, 8'd40, 10'd0, 10'h3FF, 1'b0));
    push_pixel(px(8'd40, 8'd200, 8'd39, 10'd0, 10'h3FF, 1'b0));
    push_pixel(px(8'd150, 8'd255, 8'd255, 10'd0, 10'h3FF, 1'b0));
    push_pixel(px(8'd10, 8'd255, 8'd255, 10'd0, 10'h3FF, 1'b1));
    push_pixel(px(8'd100, 8'd255, 8'd255, 10'd0, 10'h3FF, 1'b1));
    repeat (3) push_pixel(px(8'd5, 8'd200, 8'd200, 10'd5, 10'd2, 1'b0));
    push_pixel(px(8'd100, 8'd0, 8'd0, 10'd5, 10'd2, 1'b1));
    drain();

    pick_idle();
    configure(0, 0, 1, 0);
    run_phase(30, 10);
    pick_idle();
    configure(255, 255, 1024, 255);
    run_phase(20, 10);

    // One row past the column limit: a blue run crosses the saturation point,
    // a yellow run opened there closes with zero length, red ends the row.
    pick_idle();
    configure(SAT_MIN_RST, VAL_MIN_RST, 1, 0);
    for (int i = 0; i < 1037; i++) begin
      if (i < 1000) p = make_pixel(CLR_NONE);
      else if (i < 1030) p = make_pixel(CLR_BLUE);
      else if (i < 1033) p = make_pixel(CLR_YELLOW);
      else p = make_pixel(CLR_RED);
      p.track_lo = 10'd0;
      p.track_hi = 10'h3FF;
      p.row_last = (i == 1036);
      push_pixel(p);
    end
    drain();

    repeat (3) begin
      pick_idle();
      configure($urandom_range(0, 200), $urandom_range(0, 160),
                $urandom_range(1, 10), $urandom_range(0, 6));
      run_phase(25, 15);
    end

    gap_pct   = 0;
    stall_pct = 0;
    configure(SAT_MIN_RST, VAL_MIN_RST, MIN_RUN_RST, BOUND_GAP_RST);
    run_phase(30, 10);

    if (tracker.errors == 0 && tracker.coins_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/scrd_pkg.sv
rtl/core/scrd_run_tracker.sv
rtl/core/scrd_out_fifo.sv
rtl/core/scanline_color_run_detector.sv
dv/testbench.sv
